>>> rtl/qbs_lru_victim_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU victim select block
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef QBS_LRU_VICTIM_SELECT_ASSERT_SVH
`define QBS_LRU_VICTIM_SELECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication check.
`define QBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication check.
`define QBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define QBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/qbs_pkg.sv
// ----------------------------------------------------------------------------
// Package for the LRU victim select block
// Shared widths, codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package qbs_pkg;

    // Field widths fixed by the interface.
    localparam int WAYS_DEF     = 8;
    localparam int MASK_W       = 8;
    localparam int WAY_W        = 3;
    localparam int ATT_W        = 3;
    localparam int LIMIT_W      = 4;
    localparam int MAX_ATTEMPTS = 8;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd1;

    // Register index of the attempt limit (byte address 4 * index).
    localparam logic REG_ATTEMPT_LIMIT = 1'b0;

    // Request codes.
    localparam logic FUNC_TOUCH  = 1'b0;
    localparam logic FUNC_VICTIM = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_UPDATE,
        ST_DONE
    } qbs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic select;
        logic update;
        logic out_load;
    } qbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cont;
    } qbs_status_t;

endpackage

>>> rtl/qbs_lru_victim_select.sv
// ----------------------------------------------------------------------------
// LRU victim select for one cache set
// Touch and victim requests with query-based retry against the lower level.
// ----------------------------------------------------------------------------
// Sequence: an accepted input word passes through select and update, which
// repeat for each further attempt, and the result word is then loaded into the
// output register in the done state; a touch, invalid fill or first-attempt victim takes one pass.
// Throughput: one word at a time; a new word is accepted only after the result
// is loaded, which waits while a held result word keeps the output register full.
// Reset: ages return to way index order, attempt_limit returns to 1.
`include "qbs_lru_victim_select_assert.svh"

module qbs_lru_victim_select #(
    parameter int WAYS = qbs_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [qbs_pkg::WAY_W-1:0]     way,
    input  logic [qbs_pkg::MASK_W-1:0]    valid_mask,
    input  logic [qbs_pkg::MASK_W-1:0]    lower_mask,
    input  logic [qbs_pkg::MASK_W-1:0]    blocked_mask,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qbs_pkg::WAY_W-1:0]     victim_way,
    output logic                          took_invalid,
    output logic [qbs_pkg::ATT_W-1:0]     attempt_index,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [qbs_pkg::PDATA_W-1:0]   pwdata,
    output logic [qbs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import qbs_pkg::*;

    qbs_cmd_t           cmd;
    qbs_status_t        status;
    logic               limit_we;
    logic               reg_hit;
    logic [LIMIT_W-1:0] limit;
    logic               limit_in_range;

    // Register decode on the word address.
    assign pready   = 1'b1;
    assign reg_hit  = (paddr[PADDR_W-1] == REG_ATTEMPT_LIMIT);
    assign limit_we = psel && penable && pwrite && pready && reg_hit;
    assign prdata   = reg_hit ? PDATA_W'(limit) : '0;

    qbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    qbs_datapath #(
        .WAYS (WAYS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .way           (way),
        .valid_mask    (valid_mask),
        .lower_mask    (lower_mask),
        .blocked_mask  (blocked_mask),
        .limit_we      (limit_we),
        .limit_wdata   (pwdata[LIMIT_W-1:0]),
        .limit         (limit),
        .victim_way    (victim_way),
        .took_invalid  (took_invalid),
        .attempt_index (attempt_index)
    );

    // The limit needs no clamping when it lies between one and the maximum.
    assign limit_in_range = (limit != '0) && (int'(limit) <= MAX_ATTEMPTS);

    // An invalid way is always taken on the first attempt.
    `QBS_ASSERT_IMP(a_inv_first_attempt, clk, rst_n, out_valid && took_invalid, attempt_index == '0)

    // Only one word is in flight: the request side closes after an accept.
    `QBS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // The search never runs past the clamped attempt limit.
    `QBS_ASSERT_IMP(a_attempt_bound, clk, rst_n, out_valid && limit_in_range, attempt_index < limit)

endmodule

>>> rtl/qbs_ctrl.sv
// ----------------------------------------------------------------------------
// Controller for the LRU victim select block
// Sequences load, select, age update and result hand-off for one word.
// ----------------------------------------------------------------------------
module qbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  qbs_pkg::qbs_status_t status,
    output qbs_pkg::qbs_cmd_t    cmd
);
    import qbs_pkg::*;

    qbs_state_t state_reg;
    qbs_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.cont ? ST_SELECT : ST_DONE;
            end
            ST_DONE:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output word stays until it is taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/qbs_datapath.sv
// ----------------------------------------------------------------------------
// Datapath for the LRU victim select block
// Way ages, victim search, MRU update, attempt limit and result registers.
// ----------------------------------------------------------------------------
module qbs_datapath #(
    parameter int WAYS = qbs_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qbs_pkg::qbs_cmd_t             cmd,
    output qbs_pkg::qbs_status_t          status,
    input  logic                          func,
    input  logic [qbs_pkg::WAY_W-1:0]     way,
    input  logic [qbs_pkg::MASK_W-1:0]    valid_mask,
    input  logic [qbs_pkg::MASK_W-1:0]    lower_mask,
    input  logic [qbs_pkg::MASK_W-1:0]    blocked_mask,
    input  logic                          limit_we,
    input  logic [qbs_pkg::LIMIT_W-1:0]   limit_wdata,
    output logic [qbs_pkg::LIMIT_W-1:0]   limit,
    output logic [qbs_pkg::WAY_W-1:0]     victim_way,
    output logic                          took_invalid,
    output logic [qbs_pkg::ATT_W-1:0]     attempt_index
);
    import qbs_pkg::*;

    localparam int AW = $clog2(WAYS);
    localparam int MW = (WAYS > MASK_W) ? WAYS : MASK_W;

    // Mask bits above the input width read as zero.
    logic [MW-1:0]   valid_ext;
    logic [MW-1:0]   lower_ext;
    logic [MW-1:0]   blocked_ext;

    logic            func_reg;
    logic [WAY_W-1:0] way_reg;
    logic [WAYS-1:0] valid_reg;
    logic [WAYS-1:0] lower_reg;
    logic [WAYS-1:0] blocked_reg;
    logic [AW-1:0]   target_reg;
    logic [AW-1:0]   target_next;
    logic            apply_reg;
    logic            apply_next;
    logic            inv_reg;
    logic            inv_next;
    logic [ATT_W-1:0] attempt_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [AW-1:0]   age_reg  [WAYS];
    logic [AW-1:0]   age_next [WAYS];

    logic [WAY_W-1:0] victim_way_reg;
    logic            took_invalid_reg;
    logic [ATT_W-1:0] attempt_index_reg;

    logic [WAYS-1:0] elig;
    logic [WAYS-1:0] win;
    logic [AW-1:0]   pick;
    logic [AW-1:0]   first_inv;
    logic [AW-1:0]   age_tgt;
    logic [ATT_W-1:0] last_attempt;

    assign valid_ext   = MW'(valid_mask);
    assign lower_ext   = MW'(lower_mask);
    assign blocked_ext = MW'(blocked_mask);

    // Request capture; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            way_reg     <= way;
            valid_reg   <= valid_ext[WAYS-1:0];
            lower_reg   <= lower_ext[WAYS-1:0];
            blocked_reg <= blocked_ext[WAYS-1:0];
        end
        if (cmd.select)
        begin
            target_reg <= target_next;
            apply_reg  <= apply_next;
            inv_reg    <= inv_next;
        end
        if (cmd.out_load)
        begin
            victim_way_reg    <= (func_reg == FUNC_TOUCH) ? way_reg : WAY_W'(target_reg);
            took_invalid_reg  <= inv_reg;
            attempt_index_reg <= attempt_reg;
        end
    end

    // Eligible ways: not blocked and not already the youngest.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            elig[i] = !blocked_reg[i] && (age_reg[i] != '0);
        end
    end

    // A way wins if no eligible way is older, or equally old with a lower index.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            win[i] = elig[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (j != i && elig[j] &&
                    ((age_reg[j] > age_reg[i]) || ((age_reg[j] == age_reg[i]) && (j < i))))
                begin
                    win[i] = 1'b0;
                end
            end
        end
    end

    // Encode the one-hot winner; no winner gives way 0.
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (win[i])
            begin
                pick = pick | AW'(i);
            end
        end
    end

    // Lowest-numbered invalid way.
    always_comb
    begin
        first_inv = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                first_inv = AW'(i);
            end
        end
    end

    // Target way for this pass.
    always_comb
    begin
        if (func_reg == FUNC_TOUCH)
        begin
            target_next = AW'(way_reg);
            apply_next  = (int'(way_reg) < WAYS);
            inv_next    = 1'b0;
        end
        else if (valid_reg != '1)
        begin
            target_next = first_inv;
            apply_next  = 1'b1;
            inv_next    = 1'b1;
        end
        else
        begin
            target_next = pick;
            apply_next  = 1'b1;
            inv_next    = 1'b0;
        end
    end

    // MRU update: younger ways age by one, the target becomes age zero.
    assign age_tgt = age_reg[target_reg];

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (AW'(i) == target_reg)
            begin
                age_next[i] = '0;
            end
            else if (age_reg[i] < age_tgt)
            begin
                age_next[i] = age_reg[i] + 1'b1;
            end
            else
            begin
                age_next[i] = age_reg[i];
            end
        end
    end

    // Index of the last attempt, with the limit clamped to its legal range.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            last_attempt = '0;
        end
        else if (int'(limit_reg) > MAX_ATTEMPTS)
        begin
            last_attempt = ATT_W'(MAX_ATTEMPTS - 1);
        end
        else
        begin
            last_attempt = ATT_W'(limit_reg - 1'b1);
        end
    end

    // The search repeats while the chosen way sits in the lower level and attempts remain.
    assign status.cont = (func_reg == FUNC_VICTIM) && !inv_reg && lower_reg[target_reg] &&
                         (attempt_reg < last_attempt);

    // Ages, attempt counter and the limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                age_reg[i] <= AW'(i);
            end
            attempt_reg <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            if (cmd.update && apply_reg)
            begin
                age_reg <= age_next;
            end
            if (cmd.load)
            begin
                attempt_reg <= '0;
            end
            else if (cmd.update && status.cont)
            begin
                attempt_reg <= attempt_reg + 1'b1;
            end
            if (limit_we)
            begin
                limit_reg <= limit_wdata;
            end
        end
    end

    assign limit         = limit_reg;
    assign victim_way    = victim_way_reg;
    assign took_invalid  = took_invalid_reg;
    assign attempt_index = attempt_index_reg;

endmodule

>>> tb/sv/qbs_victim_pick_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Victim pick checker for the LRU victim select block
// Watches the request, result and register ports, keeps its own copy of the
// way ages and the attempt limit, predicts one result word per accepted
// request word and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module qbs_victim_pick_check #(
    parameter int WAYS = qbs_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          func,
    input  logic [qbs_pkg::WAY_W-1:0]     way,
    input  logic [qbs_pkg::MASK_W-1:0]    valid_mask,
    input  logic [qbs_pkg::MASK_W-1:0]    lower_mask,
    input  logic [qbs_pkg::MASK_W-1:0]    blocked_mask,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [qbs_pkg::WAY_W-1:0]     victim_way,
    input  logic                          took_invalid,
    input  logic [qbs_pkg::ATT_W-1:0]     attempt_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [qbs_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import qbs_pkg::*;

    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_ATTEMPT_LIMIT);

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic             took_invalid;
        logic [ATT_W-1:0] attempt_index;
    } pick_result_t;

    logic [AGE_W-1:0]   way_age [WAYS];
    logic [LIMIT_W-1:0] attempt_limit;
    pick_result_t       expected_picks [$];

    // Mask bits above the mask width read as zero.
    function automatic logic mask_at(logic [MASK_W-1:0] m, int i);
        return (i < MASK_W) ? m[i] : 1'b0;
    endfunction

    // Make way w the most recently used: every younger way ages by one.
    function automatic void promote(int w);
        logic [AGE_W-1:0] a;
        a = way_age[w];
        for (int i = 0; i < WAYS; i++)
            if (way_age[i] < a)
                way_age[i] = way_age[i] + 1'b1;
        way_age[w] = '0;
    endfunction

    // Result word for one request word; updates the ages as the block does.
    function automatic pick_result_t predict_pick(logic f, logic [WAY_W-1:0] w,
                                                  logic [MASK_W-1:0] v,
                                                  logic [MASK_W-1:0] l,
                                                  logic [MASK_W-1:0] b);
        pick_result_t r;
        int unsigned  lim;
        int unsigned  best;
        int           pick;
        r = '0;
        if (f == FUNC_TOUCH) begin
            if (int'(w) < WAYS)
                promote(int'(w));
            r.victim_way = w;
            return r;
        end

        // The lowest invalid way is taken without any search.
        for (int i = 0; i < WAYS; i++) begin
            if (!mask_at(v, i)) begin
                promote(i);
                r.victim_way   = WAY_W'(i);
                r.took_invalid = 1'b1;
                return r;
            end
        end

        // A limit of zero acts as one; anything above the maximum is clamped.
        if (attempt_limit == '0)
            lim = 1;
        else if (attempt_limit > MAX_ATTEMPTS)
            lim = MAX_ATTEMPTS;
        else
            lim = int'(attempt_limit);

        // Oldest unblocked way; way 0 when nothing qualifies. A way still held
        // below is sent to MRU and the search runs again while attempts remain.
        for (int att = 0; att < lim; att++) begin
            pick = 0;
            best = 0;
            for (int i = 0; i < WAYS; i++) begin
                if (way_age[i] > best && !mask_at(b, i)) begin
                    pick = i;
                    best = way_age[i];
                end
            end
            promote(pick);
            if (!mask_at(l, pick) || att + 1 >= lim) begin
                r.victim_way    = WAY_W'(pick);
                r.attempt_index = ATT_W'(att);
                return r;
            end
        end
        return r;
    endfunction

    // Track register writes, check result words, queue predictions.
    always @(posedge clk or negedge rst_n) begin
        pick_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < WAYS; i++)
                way_age[i] = AGE_W'(i);
            attempt_limit = LIMIT_RESET;
            expected_picks.delete();
            pending <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                attempt_limit = pwdata[LIMIT_W-1:0];

            if (out_valid && out_ready) begin
                if (expected_picks.size() == 0) begin
                    $error("result word with no request outstanding: victim_way %0d",
                           victim_way);
                    fail_count++;
                end
                else begin
                    want = expected_picks.pop_front();
                    if (victim_way !== want.victim_way) begin
                        $error("victim_way: expected %0d, got %0d",
                               want.victim_way, victim_way);
                        fail_count++;
                    end
                    if (took_invalid !== want.took_invalid) begin
                        $error("took_invalid: expected %0d, got %0d",
                               want.took_invalid, took_invalid);
                        fail_count++;
                    end
                    if (attempt_index !== want.attempt_index) begin
                        $error("attempt_index: expected %0d, got %0d",
                               want.attempt_index, attempt_index);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_picks.push_back(predict_pick(func, way, valid_mask,
                                                      lower_mask, blocked_mask));
            pending <= expected_picks.size();
        end
    end

endmodule

>>> tb/sv/qbs_lru_victim_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LRU victim select block
// Drives directed and random touch/victim request words under several attempt
// limits with random idling on both sides; the pick checker predicts and
// compares every result word, and this module reports the verdict.
// ----------------------------------------------------------------------------
module qbs_lru_victim_select_tb;
    import qbs_pkg::*;

    localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_ATTEMPT_LIMIT);
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 100;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 func          = FUNC_TOUCH;
    logic [WAY_W-1:0]     way           = '0;
    logic [MASK_W-1:0]    valid_mask    = '0;
    logic [MASK_W-1:0]    lower_mask    = '0;
    logic [MASK_W-1:0]    blocked_mask  = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [WAY_W-1:0]     victim_way;
    logic                 took_invalid;
    logic [ATT_W-1:0]     attempt_index;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;

    // Set by the stimulus for stretches where neither side idles.
    bit                   no_idle = 1'b0;
    int                   words_received = 0;
    logic [LIMIT_W-1:0]   limit_plan [PHASES];

    qbs_lru_victim_select dut (.*);

    qbs_victim_pick_check u_pick_check (.*);

    // Clock.
    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog against a hung run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one request word after a random gap and hold it until accepted.
    // Valid stays high when the next word follows without a gap.
    task automatic send_word(input logic f, input logic [WAY_W-1:0] w,
                             input logic [MASK_W-1:0] v,
                             input logic [MASK_W-1:0] l,
                             input logic [MASK_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        way          <= w;
        valid_mask   <= v;
        lower_mask   <= l;
        blocked_mask <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Random request: mostly victim words on a full set so the search and
    // retries are exercised, with some touches and partly invalid sets.
    task automatic send_random_request();
        logic              f;
        logic [WAY_W-1:0]  w;
        logic [MASK_W-1:0] v;
        logic [MASK_W-1:0] l;
        logic [MASK_W-1:0] b;
        int                sel;
        w = WAY_W'($urandom_range(0, 7));
        f = ($urandom_range(0, 9) < 3) ? FUNC_TOUCH : FUNC_VICTIM;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            v = '1;
        else if (sel < 9)
            v = ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
        else
            v = MASK_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            l = MASK_W'($urandom);
        else
            l = MASK_W'($urandom | $urandom);
        sel = $urandom_range(0, 9);
        if (sel < 4)
            b = '0;
        else if (sel < 9)
            b = MASK_W'($urandom & $urandom & $urandom);
        else
            b = '1;
        send_word(f, w, v, l, b);
    endtask

    // Drop valid and wait until every result word has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {(PDATA_W - LIMIT_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random ready gaps, and one long hold-off so the block
    // backs up and stalls its request port while words keep coming.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (!held && words_received >= 250) begin
                gap  = 160;
                held = 1'b1;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            words_received++;
        end
    end

    // Stimulus and verdict.
    initial begin
        limit_plan = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd9, 4'd2, 4'd0};
        limit_plan[PHASES-1] = LIMIT_W'($urandom_range(0, 15));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset limit of one attempt.
        send_word(FUNC_TOUCH,  3'd0, 8'h00, 8'h00, 8'h00);
        send_word(FUNC_TOUCH,  3'd7, 8'h00, 8'h00, 8'h00);
        send_word(FUNC_TOUCH,  3'd3, 8'hFF, 8'hFF, 8'hFF);
        send_word(FUNC_VICTIM, 3'd5, 8'h00, 8'h00, 8'h00);
        send_word(FUNC_VICTIM, 3'd0, 8'h7F, 8'hFF, 8'hFF);
        send_word(FUNC_VICTIM, 3'd7, 8'hEF, 8'h00, 8'h00);
        send_word(FUNC_VICTIM, 3'd2, 8'hFF, 8'h00, 8'h00);
        send_word(FUNC_VICTIM, 3'd6, 8'hFF, 8'hFF, 8'h00);
        send_word(FUNC_VICTIM, 3'd1, 8'hFF, 8'h00, 8'hFF);

        // Deepest retry chains, including one where every way is blocked.
        wait_idle();
        write_limit(4'd8);
        send_word(FUNC_VICTIM, 3'd0, 8'hFF, 8'hFF, 8'h00);
        send_word(FUNC_VICTIM, 3'd4, 8'hFF, 8'hFF, 8'hFF);
        send_word(FUNC_VICTIM, 3'd2, 8'hFF, 8'h0F, 8'h81);
        send_word(FUNC_VICTIM, 3'd7, 8'hFF, 8'hFE, 8'h00);

        // A zero limit behaves as a single attempt.
        wait_idle();
        write_limit(4'd0);
        send_word(FUNC_VICTIM, 3'd3, 8'hFF, 8'hFF, 8'h00);

        // A limit above the maximum is clamped.
        wait_idle();
        write_limit(4'd15);
        send_word(FUNC_VICTIM, 3'd1, 8'hFF, 8'hFF, 8'h00);
        send_word(FUNC_VICTIM, 3'd5, 8'hFF, 8'hAA, 8'h55);

        // Only way 7 is eligible.
        wait_idle();
        write_limit(4'd2);
        send_word(FUNC_VICTIM, 3'd6, 8'hFF, 8'hFF, 8'h7F);

        // Random phases, each under its own limit; every third one runs flat out.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_limit(limit_plan[p]);
            no_idle = (p % 3 == 1);
            repeat (PHASE_WORDS) send_random_request();
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/qbs_pkg.sv
rtl/qbs_ctrl.sv
rtl/qbs_datapath.sv
rtl/qbs_lru_victim_select.sv
tb/sv/qbs_victim_pick_check.sv
tb/sv/qbs_lru_victim_select_tb.sv
